### rtl/m2sqfb_pkg.sv
// shared constants, codes and the saturating add for the max-2sat quadratic form builder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package m2sqfb_pkg;

	localparam int MAX_VARIABLES_DEF = 63;

	localparam int FUNC_W   = 2;
	localparam int LIT_W    = 7;
	localparam int WEIGHT_W = 16;
	localparam int IDX_W    = 6;
	localparam int VAL_W    = 32;
	localparam int DELTA_W  = 18;

	localparam logic [IDX_W-1:0] COUNT_RESET = 6'd63;

	localparam logic [FUNC_W-1:0] FN_SET_LIT = 2'd0;
	localparam logic [FUNC_W-1:0] FN_CLAUSE  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_READ    = 2'd2;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_BAD_LIT  = 2'd1;
	localparam logic [1:0] STATUS_BAD_READ = 2'd2;

	// 32 bit value plus 18 bit delta, clamped to the signed 32 bit range
	function automatic logic signed [VAL_W-1:0] sat_add(
		input logic signed [VAL_W-1:0]   a,
		input logic signed [DELTA_W-1:0] d
	);
		logic signed [VAL_W:0] s;
		logic signed [VAL_W-1:0] r;
		s = {a[VAL_W-1], a} + {{(VAL_W + 1 - DELTA_W){d[DELTA_W-1]}}, d};
		if (s[VAL_W] != s[VAL_W-1]) begin
			r = s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		end else begin
			r = s[VAL_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/max2sat_quadratic_form_builder.sv
// top level of the max-2sat quadratic form builder: sequencer, matrix memory, shared adder
// depends on m2sqfb_pkg
`timescale 1ns / 1ps
`default_nettype none

// Takes one command word at a time on in_valid/in_stall and returns exactly one result word
// on out_valid/out_stall. Commands: set a literal weight, add a two-literal clause, or read a
// matrix entry. Every result carries the status and the constant term after the command.
// variable_count is to be written through cfg_wen/cfg_wdata only while the block is idle;
// the block itself does not enforce this. in_stall is low only in the idle state, so one
// command is in flight at a time. A clause takes three read-modify-writes through the single
// matrix memory (one read and one write port, registered read data) and the one shared
// saturating adder, which also updates the constant term. The result register is loaded
// in the final state, after the last update; if it still holds an untaken word the
// sequencer waits there. After reset the matrix is swept to zero, one entry a cycle,
// all (MAX_VARIABLES+1)^2 entries (4096 at the default); in_stall stays high during the
// sweep while configuration writes are taken as usual. Reset also clears the constant
// term and sets variable_count to 63.
// A stalled result holds its value until taken.
module max2sat_quadratic_form_builder #(
	parameter int MAX_VARIABLES = m2sqfb_pkg::MAX_VARIABLES_DEF
) (
	input  wire                                       clk,
	input  wire                                       arst_n,
	input  wire                                       cfg_wen,
	input  wire        [m2sqfb_pkg::IDX_W-1:0]        cfg_wdata,
	input  wire                                       in_valid,
	output logic                                      in_stall,
	input  wire        [m2sqfb_pkg::FUNC_W-1:0]       func,
	input  wire signed [m2sqfb_pkg::LIT_W-1:0]        first_literal,
	input  wire signed [m2sqfb_pkg::LIT_W-1:0]        second_literal,
	input  wire signed [m2sqfb_pkg::WEIGHT_W-1:0]     weight,
	input  wire        [m2sqfb_pkg::IDX_W-1:0]        read_row,
	input  wire        [m2sqfb_pkg::IDX_W-1:0]        read_col,
	output logic                                      out_valid,
	input  wire                                       out_stall,
	output logic       [1:0]                          status,
	output logic signed [m2sqfb_pkg::VAL_W-1:0]       entry_value,
	output logic signed [m2sqfb_pkg::VAL_W-1:0]       constant_value
);

	localparam int ORDER = MAX_VARIABLES + 1;
	localparam int DEPTH = ORDER * ORDER;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = m2sqfb_pkg::IDX_W;
	localparam int LW    = m2sqfb_pkg::LIT_W;
	localparam int WW    = m2sqfb_pkg::WEIGHT_W;
	localparam int VW    = m2sqfb_pkg::VAL_W;
	localparam int DW    = m2sqfb_pkg::DELTA_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
	localparam logic [AW-1:0] ORDER_A   = AW'(ORDER);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DEC,
		ST_RD,
		ST_C1,
		ST_C2,
		ST_C3,
		ST_DONE
	} state_t;

	state_t state_q;
	logic [AW-1:0] clr_q;
	logic [IW-1:0] vc_q;
	logic signed [VW-1:0] const_q;

	logic [m2sqfb_pkg::FUNC_W-1:0] func_q;
	logic signed [LW-1:0] la_q, lb_q;
	logic signed [WW-1:0] w_q;
	logic [IW-1:0] row_q, col_q;

	logic [1:0] res_status_q;
	logic signed [VW-1:0] res_entry_q;

	logic out_valid_q;
	logic [1:0] status_q;
	logic signed [VW-1:0] entry_q, const_out_q;

	logic [VW-1:0] mem [DEPTH];
	logic [VW-1:0] rdata_q;
	logic fwd_q;
	logic [VW-1:0] fwd_data_q;

	logic mem_we;
	logic [AW-1:0] waddr, raddr;
	logic [VW-1:0] wdata;

	logic [IW-1:0] cnt;
	logic [LW-1:0] va, vb, lo, hi;
	logic lit_ok, clause_ok, rd_ok;
	logic [AW-1:0] addr_a, addr_b, addr_c, addr_rd;
	logic signed [DW-1:0] ws, d2w, d3w, da, db, dc;
	logic signed [VW-1:0] mem_op, alu_a, alu_sum;
	logic signed [DW-1:0] alu_d;

	// active variable count
	always_comb begin
		if ({3'b000, vc_q} > 9'(MAX_VARIABLES)) begin
			cnt = IW'(MAX_VARIABLES);
		end else begin
			cnt = vc_q;
		end
	end

	// literal decode
	always_comb begin
		va = la_q[LW-1] ? LW'(-la_q) : la_q;
		vb = lb_q[LW-1] ? LW'(-lb_q) : lb_q;
		lo = (va < vb) ? va : vb;
		hi = (va < vb) ? vb : va;
		lit_ok = !la_q[LW-1] && (la_q != '0) && (la_q[IW-1:0] <= cnt);
		clause_ok = (va != '0) && (va <= {1'b0, cnt}) && (vb != '0) && (vb <= {1'b0, cnt});
		rd_ok = (row_q <= cnt) && (col_q <= cnt);
		addr_a  = AW'(va[IW-1:0]);
		addr_b  = AW'(vb[IW-1:0]);
		addr_c  = AW'(lo[IW-1:0]) * ORDER_A + AW'(hi[IW-1:0]);
		addr_rd = AW'(row_q) * ORDER_A + AW'(col_q);
	end

	// deltas for the shared adder
	always_comb begin
		ws  = {{(DW - WW){w_q[WW-1]}}, w_q};
		d2w = ws <<< 1;
		d3w = ws + d2w;
		da  = la_q[LW-1] ? -ws : ws;
		db  = lb_q[LW-1] ? -ws : ws;
		dc  = (la_q[LW-1] ^ lb_q[LW-1]) ? ws : -ws;
	end

	assign mem_op = fwd_q ? fwd_data_q : rdata_q;

	// shared saturating adder and memory port control
	always_comb begin
		alu_a  = const_q;
		alu_d  = d3w;
		mem_we = 1'b0;
		waddr  = addr_a;
		wdata  = alu_sum;
		raddr  = addr_a;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				waddr  = clr_q;
				wdata  = '0;
			end
			ST_DEC: begin
				alu_d = (func_q == m2sqfb_pkg::FN_SET_LIT) ? d2w : d3w;
				raddr = (func_q == m2sqfb_pkg::FN_READ) ? addr_rd : addr_a;
				if (func_q == m2sqfb_pkg::FN_SET_LIT && lit_ok) begin
					mem_we = 1'b1;
					wdata  = {{(VW - DW){d2w[DW-1]}}, d2w};
				end
			end
			ST_C1: begin
				alu_a  = mem_op;
				alu_d  = da;
				mem_we = 1'b1;
				raddr  = addr_b;
			end
			ST_C2: begin
				alu_a  = mem_op;
				alu_d  = db;
				mem_we = 1'b1;
				waddr  = addr_b;
				raddr  = addr_c;
			end
			ST_C3: begin
				alu_a  = mem_op;
				alu_d  = dc;
				mem_we = 1'b1;
				waddr  = addr_c;
			end
			default: begin
			end
		endcase
		alu_sum = m2sqfb_pkg::sat_add(alu_a, alu_d);
	end

	// coefficient matrix
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			vc_q        <= m2sqfb_pkg::COUNT_RESET;
			const_q     <= '0;
			out_valid_q <= 1'b0;
			fwd_q       <= 1'b0;
		end else begin
			fwd_q      <= mem_we && (waddr == raddr);
			fwd_data_q <= wdata;
			if (cfg_wen) begin
				vc_q <= cfg_wdata;
			end
			if (out_valid_q && !out_stall && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						func_q  <= func;
						la_q    <= first_literal;
						lb_q    <= second_literal;
						w_q     <= weight;
						row_q   <= read_row;
						col_q   <= read_col;
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					res_entry_q <= '0;
					unique case (func_q)
						m2sqfb_pkg::FN_SET_LIT: begin
							state_q <= ST_DONE;
							if (lit_ok) begin
								const_q      <= alu_sum;
								res_status_q <= m2sqfb_pkg::STATUS_OK;
							end else begin
								res_status_q <= m2sqfb_pkg::STATUS_BAD_LIT;
							end
						end
						m2sqfb_pkg::FN_CLAUSE: begin
							if (clause_ok) begin
								const_q      <= alu_sum;
								res_status_q <= m2sqfb_pkg::STATUS_OK;
								state_q      <= ST_C1;
							end else begin
								res_status_q <= m2sqfb_pkg::STATUS_BAD_LIT;
								state_q      <= ST_DONE;
							end
						end
						m2sqfb_pkg::FN_READ: begin
							if (rd_ok) begin
								res_status_q <= m2sqfb_pkg::STATUS_OK;
								state_q      <= ST_RD;
							end else begin
								res_status_q <= m2sqfb_pkg::STATUS_BAD_READ;
								state_q      <= ST_DONE;
							end
						end
						default: begin
							res_status_q <= m2sqfb_pkg::STATUS_OK;
							state_q      <= ST_DONE;
						end
					endcase
				end
				ST_RD: begin
					res_entry_q <= mem_op;
					state_q     <= ST_DONE;
				end
				ST_C1: begin
					state_q <= ST_C2;
				end
				ST_C2: begin
					state_q <= ST_C3;
				end
				ST_C3: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						entry_q     <= res_entry_q;
						const_out_q <= const_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall       = (state_q != ST_IDLE);
	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign entry_value    = entry_q;
	assign constant_value = const_out_q;

`ifndef SYNTH
	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_DEC))
		else $error("accepted word did not enter decode");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("result word raised outside the done state");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_DONE || state_q == ST_RD) |-> !mem_we)
		else $error("matrix written while no update is in progress");

	a_bad_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == m2sqfb_pkg::STATUS_BAD_READ) |-> (entry_value == '0))
		else $error("bad read returned a nonzero entry");
`endif

endmodule

`default_nettype wire

### tb/sv/tb_max2sat_quadratic_form_builder.sv
// testbench for max2sat_quadratic_form_builder: queued command words, a scoreboard model of the
// matrix and constant term, randomized idle and stall, and checks of every result word
// depends on m2sqfb_pkg and the max2sat_quadratic_form_builder rtl
`timescale 1ns / 1ps

module tb_max2sat_quadratic_form_builder;

	localparam logic [m2sqfb_pkg::FUNC_W-1:0] FN_UNUSED = 2'd3;
	localparam int ORDER = 64;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic [m2sqfb_pkg::FUNC_W-1:0]          fn;
		logic signed [m2sqfb_pkg::LIT_W-1:0]    lit_a;
		logic signed [m2sqfb_pkg::LIT_W-1:0]    lit_b;
		logic signed [m2sqfb_pkg::WEIGHT_W-1:0] wt;
		logic [m2sqfb_pkg::IDX_W-1:0]           row;
		logic [m2sqfb_pkg::IDX_W-1:0]           col;
	} form_cmd_t;

	typedef struct {
		logic [1:0]                          st;
		logic signed [m2sqfb_pkg::VAL_W-1:0] entry;
		logic signed [m2sqfb_pkg::VAL_W-1:0] konst;
	} form_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [m2sqfb_pkg::IDX_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [m2sqfb_pkg::FUNC_W-1:0] func = '0;
	logic signed [m2sqfb_pkg::LIT_W-1:0] first_literal = '0;
	logic signed [m2sqfb_pkg::LIT_W-1:0] second_literal = '0;
	logic signed [m2sqfb_pkg::WEIGHT_W-1:0] weight = '0;
	logic [m2sqfb_pkg::IDX_W-1:0] read_row = '0;
	logic [m2sqfb_pkg::IDX_W-1:0] read_col = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic signed [m2sqfb_pkg::VAL_W-1:0] entry_value;
	logic signed [m2sqfb_pkg::VAL_W-1:0] constant_value;

	// scoreboard copy of the block state
	int form_mat [0:ORDER-1][0:ORDER-1];
	int const_total = 0;
	int var_limit = 63;

	form_cmd_t cmd_q[$];
	form_word_t result_q[$];
	form_cmd_t cur_cmd;
	form_word_t want;

	int queued_total = 0;
	int sent_total = 0;
	int words_checked = 0;
	int error_total = 0;
	int send_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_left = 0;
	logic hold_start = 1'b0;
	int quiet_cycles = 0;

	max2sat_quadratic_form_builder dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wen        (cfg_wen),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.first_literal  (first_literal),
		.second_literal (second_literal),
		.weight         (weight),
		.read_row       (read_row),
		.read_col       (read_col),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.entry_value    (entry_value),
		.constant_value (constant_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		foreach (form_mat[r, c]) form_mat[r][c] = 0;
	end

	function automatic int sat32(input int a, input longint d);
		longint s;
		s = longint'(a) + d;
		if (s > 64'sd2147483647) return 32'sh7fffffff;
		if (s < -64'sd2147483648) return 32'sh80000000;
		return int'(s);
	endfunction

	// applies one command word to the scoreboard state and returns the expected result
	function automatic form_word_t apply_cmd(input form_cmd_t c);
		form_word_t r;
		int a, b, va, vb, sa, sb, lo, hi, w;
		a = c.lit_a;
		b = c.lit_b;
		w = c.wt;
		va = a < 0 ? -a : a;
		vb = b < 0 ? -b : b;
		sa = a > 0 ? 1 : -1;
		sb = b > 0 ? 1 : -1;
		lo = va < vb ? va : vb;
		hi = va < vb ? vb : va;
		r.st = m2sqfb_pkg::STATUS_OK;
		r.entry = 0;
		case (c.fn)
			m2sqfb_pkg::FN_SET_LIT: begin
				if (a >= 1 && a <= var_limit) begin
					form_mat[0][a] = 2 * w;
					const_total = sat32(const_total, 2 * w);
				end else begin
					r.st = m2sqfb_pkg::STATUS_BAD_LIT;
				end
			end
			m2sqfb_pkg::FN_CLAUSE: begin
				if (va >= 1 && va <= var_limit && vb >= 1 && vb <= var_limit) begin
					form_mat[0][va] = sat32(form_mat[0][va], sa * w);
					form_mat[0][vb] = sat32(form_mat[0][vb], sb * w);
					form_mat[lo][hi] = sat32(form_mat[lo][hi], -(sa * sb) * w);
					const_total = sat32(const_total, 3 * w);
				end else begin
					r.st = m2sqfb_pkg::STATUS_BAD_LIT;
				end
			end
			m2sqfb_pkg::FN_READ: begin
				if (int'(c.row) <= var_limit && int'(c.col) <= var_limit) begin
					r.entry = form_mat[c.row][c.col];
				end else begin
					r.st = m2sqfb_pkg::STATUS_BAD_READ;
				end
			end
			default: ;
		endcase
		r.konst = const_total;
		return r;
	endfunction

	function automatic logic signed [m2sqfb_pkg::LIT_W-1:0] pick_lit(input int lim,
		input int neg_pct);
		int v;
		if (lim == 0 || $urandom_range(9) == 0) return m2sqfb_pkg::LIT_W'($urandom);
		v = $urandom_range(lim, 1);
		if ($urandom_range(99) < neg_pct) v = -v;
		return m2sqfb_pkg::LIT_W'(v);
	endfunction

	function automatic logic signed [m2sqfb_pkg::WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return '0;
			3, 4, 5: return m2sqfb_pkg::WEIGHT_W'($urandom_range(512) - 256);
			default: return m2sqfb_pkg::WEIGHT_W'($urandom);
		endcase
	endfunction

	function automatic logic [m2sqfb_pkg::IDX_W-1:0] pick_idx(input int lim);
		if ($urandom_range(4) == 0) return m2sqfb_pkg::IDX_W'($urandom);
		return m2sqfb_pkg::IDX_W'($urandom_range(lim, 0));
	endfunction

	function automatic form_cmd_t make_cmd(input int lim);
		form_cmd_t c;
		int pick;
		pick = $urandom_range(19);
		c.lit_b = pick_lit(lim, 50);
		c.wt = pick_weight();
		c.row = $urandom_range(1) ? '0 : pick_idx(lim);
		c.col = pick_idx(lim);
		if (pick < 6) begin
			c.fn = m2sqfb_pkg::FN_SET_LIT;
			c.lit_a = pick_lit(lim, 10);
		end else if (pick < 14) begin
			c.fn = m2sqfb_pkg::FN_CLAUSE;
			c.lit_a = pick_lit(lim, 50);
		end else if (pick < 19) begin
			c.fn = m2sqfb_pkg::FN_READ;
			c.lit_a = pick_lit(lim, 50);
		end else begin
			c.fn = FN_UNUSED;
			c.lit_a = pick_lit(lim, 50);
		end
		return c;
	endfunction

	task automatic note_error(input string msg);
		$display("%s", msg);
		error_total++;
	endtask

	task automatic append_cmd(input form_cmd_t c);
		cmd_q = {cmd_q, c};
	endtask

	task automatic append_word(input form_word_t w);
		result_q = {result_q, w};
	endtask

	task automatic queue_cmd(input form_cmd_t c);
		append_cmd(c);
		queued_total++;
	endtask

	task automatic queue_fields(input logic [m2sqfb_pkg::FUNC_W-1:0] fn, input int a,
		input int b, input int w, input int r, input int c);
		form_cmd_t cmd;
		cmd.fn = fn;
		cmd.lit_a = m2sqfb_pkg::LIT_W'(a);
		cmd.lit_b = m2sqfb_pkg::LIT_W'(b);
		cmd.wt = m2sqfb_pkg::WEIGHT_W'(w);
		cmd.row = m2sqfb_pkg::IDX_W'(r);
		cmd.col = m2sqfb_pkg::IDX_W'(c);
		queue_cmd(cmd);
	endtask

	task automatic wait_drained();
		while (sent_total != queued_total || result_q.size() != 0) @(posedge clk);
	endtask

	// waits until every result word is back, when the block is idle, then writes the count
	task automatic load_count(input int v);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v[m2sqfb_pkg::IDX_W-1:0];
		var_limit = v;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic random_phase(input int n, input int lim, input int idle, input int stall);
		int i;
		load_count(lim);
		send_idle_pct = idle;
		rx_stall_pct = stall;
		for (i = 0; i < n; i++) queue_cmd(make_cmd(lim));
		wait_drained();
	endtask

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				append_word(apply_cmd(cur_cmd));
				sent_total++;
			end
			if (!in_valid || !in_stall) begin
				if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_cmd = cmd_q.pop_front();
					in_valid <= 1'b1;
					func <= cur_cmd.fn;
					first_literal <= cur_cmd.lit_a;
					second_literal <= cur_cmd.lit_b;
					weight <= cur_cmd.wt;
					read_row <= cur_cmd.row;
					read_col <= cur_cmd.col;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_start) hold_left <= HOLD_CYCLES;
		else if (hold_left != 0) hold_left <= hold_left - 1;
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					note_error($sformatf("result word %0d with nothing outstanding", words_checked));
				end else begin
					want = result_q.pop_front();
					if (status !== want.st)
						note_error($sformatf("word %0d: status %0d, expected %0d",
							words_checked, status, want.st));
					if (entry_value !== want.entry)
						note_error($sformatf("word %0d: entry_value %0d, expected %0d",
							words_checked, entry_value, want.entry));
					if (constant_value !== want.konst)
						note_error($sformatf("word %0d: constant_value %0d, expected %0d",
							words_checked, constant_value, want.konst));
				end
				words_checked++;
			end
			out_stall <= (hold_left != 0) || ($urandom_range(99) < rx_stall_pct);
		end
	end

	initial begin : watchdog
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
			else quiet_cycles++;
		end
		$display("timeout after %0d cycles without a transfer", WATCHDOG_LIMIT);
		$display("tb_max2sat_quadratic_form_builder: errors");
		$finish;
	end

	initial begin : stimulus
		int i, b;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// full count: extremes, every function, bad literals, same variable twice
		load_count(63);
		queue_fields(m2sqfb_pkg::FN_READ, 0, 0, 0, 0, 0);
		queue_fields(m2sqfb_pkg::FN_SET_LIT, 1, 0, 32767, 0, 0);
		queue_fields(m2sqfb_pkg::FN_SET_LIT, 63, 0, -32768, 0, 0);
		queue_fields(m2sqfb_pkg::FN_SET_LIT, 0, 0, 500, 0, 0);
		queue_fields(m2sqfb_pkg::FN_SET_LIT, -5, 0, 500, 0, 0);
		queue_fields(m2sqfb_pkg::FN_SET_LIT, -64, 0, 500, 0, 0);
		queue_fields(m2sqfb_pkg::FN_CLAUSE, 1, -63, 100, 0, 0);
		queue_fields(m2sqfb_pkg::FN_CLAUSE, -63, 63, -32768, 0, 0);
		queue_fields(m2sqfb_pkg::FN_CLAUSE, 5, 5, 256, 0, 0);
		queue_fields(m2sqfb_pkg::FN_CLAUSE, 0, 3, 700, 0, 0);
		queue_fields(m2sqfb_pkg::FN_CLAUSE, 3, -64, 700, 0, 0);
		queue_fields(m2sqfb_pkg::FN_READ, 0, 0, 0, 0, 1);
		queue_fields(m2sqfb_pkg::FN_READ, 0, 0, 0, 63, 63);
		queue_fields(m2sqfb_pkg::FN_READ, 0, 0, 0, 5, 5);
		queue_fields(m2sqfb_pkg::FN_READ, 0, 0, 0, 63, 1);
		queue_fields(FN_UNUSED, -1, 63, -1, 63, 63);
		queue_fields(m2sqfb_pkg::FN_SET_LIT, 1, 0, 0, 0, 0);

		// small count: literals and read indexes just above it
		load_count(2);
		queue_fields(m2sqfb_pkg::FN_SET_LIT, 3, 0, 10, 0, 0);
		queue_fields(m2sqfb_pkg::FN_CLAUSE, 1, -3, 10, 0, 0);
		queue_fields(m2sqfb_pkg::FN_CLAUSE, -2, 1, -1, 0, 0);
		queue_fields(m2sqfb_pkg::FN_READ, 0, 0, 0, 3, 0);
		queue_fields(m2sqfb_pkg::FN_READ, 0, 0, 0, 0, 3);
		queue_fields(m2sqfb_pkg::FN_READ, 0, 0, 0, 2, 2);
		queue_fields(m2sqfb_pkg::FN_READ, 0, 0, 0, 0, 2);
		queue_fields(m2sqfb_pkg::FN_READ, 0, 0, 0, 1, 2);

		random_phase(450, 63, 0, 0);
		random_phase(350, 5, 61, 0);
		random_phase(350, 1, 0, 61);
		random_phase(350, 20, 37, 37);
		random_phase(100, 0, 37, 37);

		// output held off while commands keep coming, then bursts with full drains between
		load_count(12);
		send_idle_pct = 0;
		rx_stall_pct = 0;
		@(posedge clk);
		hold_start <= 1'b1;
		@(posedge clk);
		hold_start <= 1'b0;
		for (i = 0; i < 60; i++) queue_cmd(make_cmd(12));
		wait_drained();
		for (b = 0; b < 3; b++) begin
			for (i = 0; i < 40; i++) queue_cmd(make_cmd(12));
			wait_drained();
		end

		// back to back heavy clauses on variable 1 and then variable 2, largest weights of both signs
		load_count(63);
		for (i = 0; i < 20; i++) begin
			queue_fields(m2sqfb_pkg::FN_CLAUSE, 1, 1, 32767, 0, 0);
			if (i % 10 == 0) begin
				queue_fields(m2sqfb_pkg::FN_READ, 0, 0, 0, 0, 1);
				queue_fields(m2sqfb_pkg::FN_READ, 0, 0, 0, 1, 1);
			end
		end
		for (i = 0; i < 20; i++) begin
			queue_fields(m2sqfb_pkg::FN_CLAUSE, 2, 2, -32768, 0, 0);
			if (i % 10 == 0) begin
				queue_fields(m2sqfb_pkg::FN_READ, 0, 0, 0, 0, 2);
				queue_fields(m2sqfb_pkg::FN_READ, 0, 0, 0, 2, 2);
			end
		end
		queue_fields(m2sqfb_pkg::FN_READ, 0, 0, 0, 0, 1);
		wait_drained();
		repeat (20) @(posedge clk);

		$display("run covered %0d commands and %0d result words, variable counts 0 to 63,",
			sent_total, words_checked);
		$display("idle and stall mixes, a long output hold-off and heavy clause runs");
		if (error_total == 0) begin
			$display("tb_max2sat_quadratic_form_builder: clean");
		end else begin
			$display("%0d mismatches", error_total);
			$display("tb_max2sat_quadratic_form_builder: errors");
		end
		$finish;
	end

endmodule
